FILE: rtl/box3_pkg.sv
// ----------------------------------------------------------------------------
// box3_pkg
// Shared types and constants of the clipped 3x3 box filter.
// ----------------------------------------------------------------------------
package box3_pkg;

  localparam int unsigned MaxSize  = 1024;
  localparam int unsigned PosW     = $clog2(MaxSize);
  localparam int unsigned SizeW    = PosW + 1;
  localparam int unsigned ChW      = 16;
  localparam int unsigned NumCh    = 3;
  localparam int unsigned SumW     = ChW + 4;
  localparam int unsigned RecipW   = 21;
  localparam int unsigned ProdW    = SumW + RecipW;
  localparam int unsigned ShW      = 5;

  // Exact floor division of a SumW-bit sum: q = (s * K) >> SH.
  localparam logic [RecipW-1:0] RecipOne   = RecipW'(1);
  localparam logic [RecipW-1:0] RecipThree = RecipW'(1398102);
  localparam logic [RecipW-1:0] RecipSix   = RecipW'(1398102);
  localparam logic [RecipW-1:0] RecipNine  = RecipW'(1864136);
  localparam logic [ShW-1:0]    ShThree    = ShW'(22);
  localparam logic [ShW-1:0]    ShSix      = ShW'(23);
  localparam logic [ShW-1:0]    ShNine     = ShW'(24);

  typedef logic [NumCh-1:0][ChW-1:0] pixel_t;
  typedef logic [PosW-1:0]           pos_t;

  // Which output a pixel at (r,c) releases, in release order.
  typedef logic [1:0] kind_t;
  localparam kind_t KindUpLeft = 2'd0;  // (r-1, c-1)
  localparam kind_t KindUp     = 2'd1;  // (r-1, c)
  localparam kind_t KindLeft   = 2'd2;  // (r, c-1)
  localparam kind_t KindHere   = 2'd3;  // (r, c)

  typedef struct packed {
    logic  accept;     // input transfer: capture pixel, read line stores
    logic  update;     // shift window, write line stores
    logic  sum_en;     // sum clipped window for kind
    kind_t kind;
    logic  mul_en;     // reciprocal multiply
    logic  load_out;   // load output register
    logic  run_last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] emit_mask;  // one bit per kind
  } sts_t;

endpackage

FILE: rtl/box3_ctrl.sv
// ----------------------------------------------------------------------------
// box3_ctrl
// Sequencer: takes one pixel, updates the window, then walks the released
// outputs through sum, multiply and the output register.
// ----------------------------------------------------------------------------
module box3_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  box3_pkg::sts_t  sts_i,
  output box3_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StUpdate,
    StSum,
    StMul,
    StOut
  } state_e;

  state_e     state_q;
  logic [3:0] pend_q;
  logic       out_valid_q;
  logic [3:0] pend_rest;
  logic       load;
  box3_pkg::kind_t kind;

  always_comb begin
    if (pend_q[0]) begin
      kind = box3_pkg::KindUpLeft;
    end else if (pend_q[1]) begin
      kind = box3_pkg::KindUp;
    end else if (pend_q[2]) begin
      kind = box3_pkg::KindLeft;
    end else begin
      kind = box3_pkg::KindHere;
    end
  end

  // drop lowest pending bit
  assign pend_rest = pend_q & (pend_q - 4'd1);
  assign load      = (state_q == StOut) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = in_valid_i && (state_q == StIdle);
    cmd_o.update   = (state_q == StUpdate);
    cmd_o.sum_en   = (state_q == StSum);
    cmd_o.kind     = kind;
    cmd_o.mul_en   = (state_q == StMul);
    cmd_o.load_out = load;
    cmd_o.run_last = (pend_rest == 4'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StUpdate;
          end
        end
        StUpdate: begin
          pend_q  <= sts_i.emit_mask;
          state_q <= (sts_i.emit_mask == 4'd0) ? StIdle : StSum;
        end
        StSum: begin
          state_q <= StMul;
        end
        StMul: begin
          state_q <= StOut;
        end
        StOut: begin
          if (load) begin
            pend_q  <= pend_rest;
            state_q <= (pend_rest == 4'd0) ? StIdle : StSum;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

FILE: rtl/box3_dp.sv
// ----------------------------------------------------------------------------
// box3_dp
// Datapath: image size, position, line stores, 3x3 window, clipped sum,
// reciprocal divide and output register.
// ----------------------------------------------------------------------------
module box3_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_write_i,
  input  logic [box3_pkg::SizeW-1:0]     cfg_data_i,
  input  box3_pkg::pixel_t               pix_i,
  input  box3_pkg::cmd_t                 cmd_i,
  output box3_pkg::sts_t                 sts_o,
  output logic [box3_pkg::PosW-1:0]      out_row_o,
  output logic [box3_pkg::PosW-1:0]      out_col_o,
  output box3_pkg::pixel_t               out_pix_o,
  output logic                           run_last_o,
  output logic                           frame_done_o
);

  localparam int unsigned SizeW = box3_pkg::SizeW;
  localparam int unsigned PosW  = box3_pkg::PosW;
  localparam int unsigned SumW  = box3_pkg::SumW;
  localparam int unsigned ProdW = box3_pkg::ProdW;
  localparam int unsigned ChW   = box3_pkg::ChW;
  localparam int unsigned NumCh = box3_pkg::NumCh;

  // Control-side registers
  box3_pkg::pos_t last_q, row_q, col_q;

  // Line stores, undefined until written
  box3_pkg::pixel_t older_mem [box3_pkg::MaxSize];
  box3_pkg::pixel_t newer_mem [box3_pkg::MaxSize];
  box3_pkg::pixel_t rd_old_q, rd_new_q, pix_q;
  box3_pkg::pos_t   pix_r_q, pix_c_q;

  box3_pkg::pixel_t win_q [3][3];

  logic [NumCh-1:0][SumW-1:0]  sum_d, sum_q;
  logic [NumCh-1:0][ProdW-1:0] prod_q;
  logic [box3_pkg::RecipW-1:0] recip_d, recip_q;
  logic [box3_pkg::ShW-1:0]    sh_d, sh_q;
  box3_pkg::pos_t              orow_d, ocol_d, orow_q, ocol_q;
  logic                        fdone_q;
  logic [2:0]                  rmask, cmask;
  logic [1:0]                  rcnt, ccnt;
  logic [3:0]                  cnt;
  logic                        dr, dc;
  box3_pkg::pos_t              last_d;

  // Clamp written size to 1..MaxSize, keep it as the last index
  always_comb begin
    if (cfg_data_i == '0) begin
      last_d = '0;
    end else if (cfg_data_i > SizeW'(box3_pkg::MaxSize)) begin
      last_d = PosW'(box3_pkg::MaxSize - 1);
    end else begin
      last_d = PosW'(cfg_data_i - SizeW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= PosW'(box3_pkg::MaxSize - 1);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_write_i) begin
      last_q <= last_d;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cmd_i.accept) begin
      if (col_q == last_q) begin
        col_q <= '0;
        row_q <= (row_q == last_q) ? '0 : row_q + PosW'(1);
      end else begin
        col_q <= col_q + PosW'(1);
      end
    end
  end

  // Line store read on transfer, written back in the following cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_old_q <= older_mem[col_q];
      rd_new_q <= newer_mem[col_q];
      pix_q    <= pix_i;
      pix_r_q  <= row_q;
      pix_c_q  <= col_q;
    end
    if (cmd_i.update) begin
      older_mem[pix_c_q] <= rd_new_q;
      newer_mem[pix_c_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int wr = 0; wr < 3; wr++) begin
        win_q[wr][0] <= win_q[wr][1];
        win_q[wr][1] <= win_q[wr][2];
      end
      win_q[0][2] <= rd_old_q;
      win_q[1][2] <= rd_new_q;
      win_q[2][2] <= pix_q;
    end
  end

  assign sts_o.emit_mask = {
    (pix_r_q == last_q) && (pix_c_q == last_q),
    (pix_r_q == last_q) && (pix_c_q != '0),
    (pix_r_q != '0)     && (pix_c_q == last_q),
    (pix_r_q != '0)     && (pix_c_q != '0)
  };

  // Window row 2 / column 2 hold the newest pixel; clip by masks
  always_comb begin
    dr     = (cmd_i.kind == box3_pkg::KindUpLeft) || (cmd_i.kind == box3_pkg::KindUp);
    dc     = (cmd_i.kind == box3_pkg::KindUpLeft) || (cmd_i.kind == box3_pkg::KindLeft);
    orow_d = pix_r_q - PosW'(dr);
    ocol_d = pix_c_q - PosW'(dc);
    rmask  = {1'b1, dr || (orow_d != '0), dr && (orow_d != '0)};
    cmask  = {1'b1, dc || (ocol_d != '0), dc && (ocol_d != '0)};
    rcnt   = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);
    ccnt   = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);
    cnt    = 4'(rcnt) * 4'(ccnt);
    sum_d  = '0;
    for (int wr = 0; wr < 3; wr++) begin
      for (int wc = 0; wc < 3; wc++) begin
        if (rmask[wr] && cmask[wc]) begin
          for (int ch = 0; ch < NumCh; ch++) begin
            sum_d[ch] = sum_d[ch] + SumW'(win_q[wr][wc][ch]);
          end
        end
      end
    end
    case (cnt)
      4'd1: begin recip_d = box3_pkg::RecipOne;   sh_d = '0;               end
      4'd2: begin recip_d = box3_pkg::RecipOne;   sh_d = 5'd1;             end
      4'd3: begin recip_d = box3_pkg::RecipThree; sh_d = box3_pkg::ShThree; end
      4'd4: begin recip_d = box3_pkg::RecipOne;   sh_d = 5'd2;             end
      4'd6: begin recip_d = box3_pkg::RecipSix;   sh_d = box3_pkg::ShSix;   end
      4'd9: begin recip_d = box3_pkg::RecipNine;  sh_d = box3_pkg::ShNine;  end
      default: begin recip_d = '0;                sh_d = '0;               end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sum_q   <= sum_d;
      recip_q <= recip_d;
      sh_q    <= sh_d;
      orow_q  <= orow_d;
      ocol_q  <= ocol_d;
      fdone_q <= (orow_d == last_q) && (ocol_d == last_q);
    end
    if (cmd_i.mul_en) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        prod_q[ch] <= ProdW'(sum_q[ch]) * ProdW'(recip_q);
      end
    end
    if (cmd_i.load_out) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        out_pix_o[ch] <= ChW'(prod_q[ch] >> sh_q);
      end
      out_row_o    <= orow_q;
      out_col_o    <= ocol_q;
      run_last_o   <= cmd_i.run_last;
      frame_done_o <= fdone_q;
    end
  end

endmodule

FILE: rtl/box_filter_3x3_clipped.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_clipped
// Streaming 3x3 floor-mean filter on a square RGB image, borders clipped.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_* valid/ready channel, one per
// transfer. Each transfer releases zero to four smoothed pixels on the out_*
// valid/ready channel, tagged with row and column; run_last marks the last
// result of a transfer, frame_done the bottom-right pixel of the image.
// cfg_data_i sets the image size (0 acts as 1, above 1024 as 1024) and
// restarts the frame at (0,0); write it only while the block is idle.
// Sequence: a pixel passes the update state, then each released result passes
// sum, multiply and output load; one result is sequenced at a time by the
// controller. The first result is valid after update, sum, multiply and load.
// The output register lets the next pixel be taken while the last result
// still waits. If the receiver stalls, the block holds in its output state
// and stops taking pixels once the next result is ready.
// Reset sets the size to 1024 and the position to (0,0); line stores are not
// cleared (every entry used in a frame is written first).
// ----------------------------------------------------------------------------
module box_filter_3x3_clipped (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] in_red_i,
  input  logic [15:0] in_green_i,
  input  logic [15:0] in_blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  out_row_o,
  output logic [9:0]  out_col_o,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic        run_last_o,
  output logic        frame_done_o
);

  box3_pkg::cmd_t   cmd;
  box3_pkg::sts_t   sts;
  box3_pkg::pixel_t in_pix, out_pix;

  assign cfg_ready_o = 1'b1;
  assign in_pix      = {in_blue_i, in_green_i, in_red_i};
  assign out_red_o   = out_pix[0];
  assign out_green_o = out_pix[1];
  assign out_blue_o  = out_pix[2];

  box3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  box3_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_write_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .pix_i        (in_pix),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_pix_o    (out_pix),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

endmodule
